>>> rtl/core/bffre_pkg.sv
// ----------------------------------------------------------------------------
// bffre_pkg: shared types and constants of the block flag/fill/raw expander
// Field widths, item kind codes, register indexes and the structs passed
// between the configuration, engine and result queue modules.
// ----------------------------------------------------------------------------
package bffre_pkg;

  // Limits of the effective configuration
  localparam int unsigned MAX_BLOCK = 8;
  localparam int unsigned MAX_DIM   = 4096;

  // Field and internal widths
  localparam int DIM_W      = 13;  // image width/height registers
  localparam int COORD_W    = 12;  // pixel column/row
  localparam int SIDE_W     = 4;   // block side
  localparam int SUB_W      = 3;   // position inside a block
  localparam int STRIDE_W   = 3;   // bytes per pixel
  localparam int PLANE_W    = 2;   // plane select
  localparam int OFF_W      = 26;  // byte offset
  localparam int DATA_W     = 32;  // item data and pixel value
  localparam int PIX_W      = 24;  // linear pixel index
  localparam int SW_W       = 16;  // block side times image width
  localparam int OP_W       = 2;
  localparam int FLAG_W     = 8;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 13;

  // Item kinds
  localparam logic [OP_W-1:0] OP_FLAG = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL = 2'd1;
  localparam logic [OP_W-1:0] OP_RAW  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIDE      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DECODE_MODE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_SELECT    = 3'd5;

  // Flag bit of the first block in a flag byte
  localparam logic [FLAG_W-1:0] FIRST_FLAG_BIT = 8'h80;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [SIDE_W-1:0]   side;
    logic                mode;
    logic [STRIDE_W-1:0] stride;
    logic [PLANE_W-1:0]  plane;
    logic [SW_W-1:0]     side_w;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic               pixel_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [OFF_W-1:0]   byte_offset;
    logic [DATA_W-1:0]  pixel_value;
    logic               block_done;
    logic               image_done;
    logic               kind_error;
  } result_t;

endpackage

>>> rtl/core/bffre_if.sv
// ----------------------------------------------------------------------------
// bffre_if: channel interfaces of the block flag/fill/raw expander
// Input item channel, result channel and register write channel, each with
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface bffre_in_if
  import bffre_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] item_data;

  modport source (output valid, output op, output item_data, input ready);
  modport sink   (input valid, input op, input item_data, output ready);
endinterface

interface bffre_out_if
  import bffre_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               pixel_valid;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [OFF_W-1:0]   byte_offset;
  logic [DATA_W-1:0]  pixel_value;
  logic               block_done;
  logic               image_done;
  logic               kind_error;

  modport source (output valid, output pixel_valid, output pixel_x, output pixel_y,
                  output byte_offset, output pixel_value, output block_done,
                  output image_done, output kind_error, input ready);
  modport sink   (input valid, input pixel_valid, input pixel_x, input pixel_y,
                  input byte_offset, input pixel_value, input block_done,
                  input image_done, input kind_error, output ready);
endinterface

interface bffre_cfg_if
  import bffre_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [REG_DATA_W-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

>>> rtl/core/bffre_cfg_regs.sv
// ----------------------------------------------------------------------------
// bffre_cfg_regs: configuration registers
// Holds the six registers, clamps them to their working ranges and pulses a
// traversal restart on every write to a register in the list.
// ----------------------------------------------------------------------------
module bffre_cfg_regs
  import bffre_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  logic [REG_IDX_W-1:0]  wr_index_i,
  input  logic [REG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o,
  output logic                  restart_o
);

  logic [DIM_W-1:0]    width_q;
  logic [DIM_W-1:0]    height_q;
  logic [SIDE_W-1:0]   side_q;
  logic                mode_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [PLANE_W-1:0]  plane_q;
  logic                wr_fire;
  logic                idx_known;

  assign wr_ready_o = 1'b1;
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign idx_known  = (wr_index_i == REG_IMAGE_WIDTH) || (wr_index_i == REG_IMAGE_HEIGHT) ||
                      (wr_index_i == REG_BLOCK_SIDE) || (wr_index_i == REG_DECODE_MODE) ||
                      (wr_index_i == REG_BYTES_PER_PIXEL) || (wr_index_i == REG_PLANE_SELECT);
  assign restart_o  = wr_fire && idx_known;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      side_q   <= SIDE_W'(8);
      mode_q   <= 1'b0;
      stride_q <= STRIDE_W'(4);
      plane_q  <= '0;
    end else if (wr_fire) begin
      case (wr_index_i)
        REG_IMAGE_WIDTH:     width_q  <= wr_data_i;
        REG_IMAGE_HEIGHT:    height_q <= wr_data_i;
        REG_BLOCK_SIDE:      side_q   <= wr_data_i[SIDE_W-1:0];
        REG_DECODE_MODE:     mode_q   <= wr_data_i[0];
        REG_BYTES_PER_PIXEL: stride_q <= wr_data_i[STRIDE_W-1:0];
        REG_PLANE_SELECT:    plane_q  <= wr_data_i[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the working ranges
  always_comb begin
    cfg_o = '0;
    if (width_q == '0)                     cfg_o.width = DIM_W'(1);
    else if (width_q > DIM_W'(MAX_DIM))    cfg_o.width = DIM_W'(MAX_DIM);
    else                                   cfg_o.width = width_q;
    if (height_q == '0)                    cfg_o.height = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_DIM))   cfg_o.height = DIM_W'(MAX_DIM);
    else                                   cfg_o.height = height_q;
    if (side_q == '0)                      cfg_o.side = SIDE_W'(1);
    else if (side_q > SIDE_W'(MAX_BLOCK))  cfg_o.side = SIDE_W'(MAX_BLOCK);
    else                                   cfg_o.side = side_q;
    if (stride_q == '0)                    cfg_o.stride = STRIDE_W'(1);
    else if (stride_q > STRIDE_W'(4))      cfg_o.stride = STRIDE_W'(4);
    else                                   cfg_o.stride = stride_q;
    cfg_o.mode   = mode_q;
    cfg_o.plane  = plane_q;
    cfg_o.side_w = SW_W'({{(SW_W-SIDE_W){1'b0}}, cfg_o.side} *
                         {{(SW_W-DIM_W){1'b0}}, cfg_o.width});
  end

endmodule

>>> rtl/core/bffre_out_fifo.sv
// ----------------------------------------------------------------------------
// bffre_out_fifo: two-entry result queue
// Decouples the engine from the result channel so that a new item can be
// taken while a finished result is still waiting downstream.
// ----------------------------------------------------------------------------
module bffre_out_fifo
  import bffre_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    room_o,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output result_t pop_data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign room_o      = (cnt_q != 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign pop         = pop_valid_o && pop_ready_i;

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/bffre_engine.sv
// ----------------------------------------------------------------------------
// bffre_engine: block traversal and pixel emitter
// Registers the incoming item, tracks the block walk and flag bits, and
// produces at most one result beat per cycle: one per raw sample, one per
// pixel of a filled block, and markers for errors and skipped image ends.
// ----------------------------------------------------------------------------
module bffre_engine
  import bffre_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              restart_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   in_op_i,
  input  logic [DATA_W-1:0] in_data_i,
  input  logic              room_i,
  output logic              push_o,
  output result_t           push_data_o
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;

  // Input register
  logic              in_vld_q;
  logic [OP_W-1:0]   in_op_q;
  logic [DATA_W-1:0] in_data_q;
  logic              consume;

  // Traversal state
  logic [1:0]         st_q, st_d;
  logic [COORD_W-1:0] blk_x_q, blk_x_d;
  logic [COORD_W-1:0] blk_y_q, blk_y_d;
  logic [PIX_W-1:0]   ybase_q, ybase_d;
  logic [PIX_W-1:0]   rbase_q, rbase_d;
  logic [SUB_W-1:0]   row_q, row_d;
  logic [SUB_W-1:0]   col_q, col_d;
  logic [FLAG_W-1:0]  flags_q, flags_d;
  logic [SUB_W-1:0]   idx_q, idx_d;
  logic [OP_W-1:0]    expect_q, expect_d;
  logic [FLAG_W-1:0]  fill_q, fill_d;
  result_t            pend_q, pend_d;
  logic               pend_push_q, pend_push_d;

  // Block advance
  logic [FLAG_W-1:0]  step_flags;
  logic [SUB_W-1:0]   step_idx;
  logic [DIM_W-1:0]   nx, ny;
  logic               wrap_x, wrap_y;
  logic [COORD_W-1:0] stp_x, stp_y;
  logic [PIX_W-1:0]   stp_ybase;
  logic [SUB_W-1:0]   stp_idx;
  logic [OP_W-1:0]    stp_expect;
  logic               stp_stop, stp_done;
  logic               stp_bit;
  logic               take_step;

  // Pixel emission
  logic [COORD_W-1:0] px, py;
  logic [PIX_W-1:0]   pix;
  logic [OFF_W-1:0]   pix_ext, pix_scaled;
  logic [DIM_W-1:0]   dx, dy;
  logic [SIDE_W-1:0]  bw, bh;
  logic               last_col, last_row, block_end;
  logic [DATA_W-1:0]  pix_src;
  result_t            pix_res;
  result_t            marker;
  logic               pix_go;
  logic               first_bit;

  assign consume    = (st_q == ST_RUN) && in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || consume;
  assign first_bit  = |(in_data_q[FLAG_W-1:0] & FIRST_FLAG_BIT);

  // Hold the accepted item until the engine takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (consume) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_op_q   <= in_op_i;
      in_data_q <= in_data_i;
    end
  end

  // Advance one block and pick what the next block expects
  always_comb begin
    step_flags = ((st_q == ST_RUN) && (in_op_q == OP_FLAG)) ? in_data_q[FLAG_W-1:0] : flags_q;
    step_idx   = ((st_q == ST_RUN) && (in_op_q == OP_FLAG)) ? '0 : idx_q;
    nx         = {1'b0, blk_x_q} + {{(DIM_W-SIDE_W){1'b0}}, cfg_i.side};
    ny         = {1'b0, blk_y_q} + {{(DIM_W-SIDE_W){1'b0}}, cfg_i.side};
    wrap_x     = (nx >= cfg_i.width);
    wrap_y     = (ny >= cfg_i.height);
    stp_x      = wrap_x ? '0 : nx[COORD_W-1:0];
    stp_y      = wrap_x ? ny[COORD_W-1:0] : blk_y_q;
    stp_ybase  = wrap_x ? ybase_q + {{(PIX_W-SW_W){1'b0}}, cfg_i.side_w} : ybase_q;
    stp_idx    = step_idx + 3'd1;
    stp_bit    = |(step_flags & (FIRST_FLAG_BIT >> stp_idx));
    stp_expect = expect_q;
    stp_stop   = 1'b1;
    stp_done   = 1'b0;
    if (wrap_x && wrap_y) begin
      stp_done   = 1'b1;
      stp_x      = '0;
      stp_y      = '0;
      stp_ybase  = '0;
      stp_idx    = '0;
      stp_expect = OP_FLAG;
    end else if (step_idx == 3'd7) begin
      stp_idx    = '0;
      stp_expect = OP_FLAG;
    end else if (!cfg_i.mode) begin
      stp_expect = stp_bit ? OP_FILL : OP_RAW;
    end else if (!stp_bit) begin
      stp_expect = OP_RAW;
    end else begin
      stp_expect = OP_RAW;
      stp_stop   = 1'b0;
    end
  end

  // Build the pixel beat for the current block position
  always_comb begin
    px       = blk_x_q + {{(COORD_W-SUB_W){1'b0}}, col_q};
    py       = blk_y_q + {{(COORD_W-SUB_W){1'b0}}, row_q};
    pix      = rbase_q + {{(PIX_W-COORD_W){1'b0}}, px};
    pix_ext  = {{(OFF_W-PIX_W){1'b0}}, pix};
    dx       = cfg_i.width - {1'b0, blk_x_q};
    dy       = cfg_i.height - {1'b0, blk_y_q};
    bw       = (dx < {{(DIM_W-SIDE_W){1'b0}}, cfg_i.side}) ? dx[SIDE_W-1:0] : cfg_i.side;
    bh       = (dy < {{(DIM_W-SIDE_W){1'b0}}, cfg_i.side}) ? dy[SIDE_W-1:0] : cfg_i.side;
    last_col = ({1'b0, col_q} == bw - 4'd1);
    last_row = ({1'b0, row_q} == bh - 4'd1);
    block_end = last_col && last_row;
    pix_src  = (st_q == ST_FILL) ? {{(DATA_W-FLAG_W){1'b0}}, fill_q} : in_data_q;
    case (cfg_i.stride)
      3'd1:    pix_scaled = pix_ext;
      3'd2:    pix_scaled = pix_ext << 1;
      3'd3:    pix_scaled = pix_ext + (pix_ext << 1);
      default: pix_scaled = pix_ext << 2;
    endcase
    pix_res             = '0;
    pix_res.pixel_valid = 1'b1;
    pix_res.pixel_x     = px;
    pix_res.pixel_y     = py;
    if (cfg_i.mode) begin
      pix_res.byte_offset = pix_ext << 2;
      pix_res.pixel_value = pix_src;
    end else begin
      pix_res.byte_offset = pix_scaled + {{(OFF_W-PLANE_W){1'b0}}, cfg_i.plane};
      pix_res.pixel_value = {{(DATA_W-FLAG_W){1'b0}}, pix_src[FLAG_W-1:0]};
    end
  end

  // Sequence items, fill bursts and skipped blocks
  always_comb begin
    st_d        = st_q;
    blk_x_d     = blk_x_q;
    blk_y_d     = blk_y_q;
    ybase_d     = ybase_q;
    rbase_d     = rbase_q;
    row_d       = row_q;
    col_d       = col_q;
    flags_d     = flags_q;
    idx_d       = idx_q;
    expect_d    = expect_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    pend_push_d = pend_push_q;
    push_o      = 1'b0;
    push_data_o = '0;
    take_step   = 1'b0;
    pix_go      = 1'b0;
    marker      = '0;

    case (st_q)
      ST_RUN: begin
        if (consume) begin
          if (in_op_q != expect_q) begin
            push_o                 = 1'b1;
            push_data_o.kind_error = 1'b1;
            push_data_o.block_done = 1'b1;
          end else if (in_op_q == OP_FLAG) begin
            flags_d = in_data_q[FLAG_W-1:0];
            idx_d   = '0;
            if (!cfg_i.mode) begin
              expect_d = first_bit ? OP_FILL : OP_RAW;
            end else if (!first_bit) begin
              expect_d = OP_RAW;
            end else begin
              take_step = 1'b1;
              marker.block_done = 1'b1;
              if (stp_stop) begin
                if (stp_done) begin
                  push_o                 = 1'b1;
                  push_data_o            = marker;
                  push_data_o.image_done = 1'b1;
                end
              end else begin
                st_d        = ST_SKIP;
                pend_d      = marker;
                pend_push_d = 1'b0;
              end
            end
          end else begin
            pix_go = 1'b1;
            if (in_op_q == OP_FILL) fill_d = in_data_q[FLAG_W-1:0];
          end
        end
      end
      ST_FILL: begin
        if (room_i) pix_go = 1'b1;
      end
      ST_SKIP: begin
        if (room_i) begin
          take_step = 1'b1;
          if (stp_stop) begin
            st_d = ST_RUN;
            if (pend_push_q || stp_done) begin
              push_o                 = 1'b1;
              push_data_o            = pend_q;
              push_data_o.image_done = stp_done;
            end
          end
        end
      end
      default: st_d = ST_RUN;
    endcase

    // Emit one pixel and move inside the block
    if (pix_go) begin
      if (block_end) begin
        take_step = 1'b1;
        if (stp_stop) begin
          push_o                 = 1'b1;
          push_data_o            = pix_res;
          push_data_o.block_done = 1'b1;
          push_data_o.image_done = stp_done;
          st_d                   = ST_RUN;
        end else begin
          st_d              = ST_SKIP;
          pend_d            = pix_res;
          pend_d.block_done = 1'b1;
          pend_push_d       = 1'b1;
        end
      end else begin
        push_o                 = 1'b1;
        push_data_o            = pix_res;
        push_data_o.block_done = (st_q == ST_RUN) && (in_op_q == OP_RAW);
        if (last_col) begin
          col_d   = '0;
          row_d   = row_q + 3'd1;
          rbase_d = rbase_q + {{(PIX_W-DIM_W){1'b0}}, cfg_i.width};
        end else begin
          col_d = col_q + 3'd1;
        end
        if ((st_q == ST_RUN) && (in_op_q == OP_FILL)) st_d = ST_FILL;
      end
    end

    // Commit the block advance
    if (take_step) begin
      blk_x_d  = stp_x;
      blk_y_d  = stp_y;
      ybase_d  = stp_ybase;
      rbase_d  = stp_ybase;
      row_d    = '0;
      col_d    = '0;
      idx_d    = stp_idx;
      expect_d = stp_expect;
      flags_d  = stp_done ? '0 : step_flags;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      blk_x_q     <= '0;
      blk_y_q     <= '0;
      ybase_q     <= '0;
      rbase_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      flags_q     <= '0;
      idx_q       <= '0;
      expect_q    <= OP_FLAG;
      pend_push_q <= 1'b0;
    end else if (restart_i) begin
      st_q        <= ST_RUN;
      blk_x_q     <= '0;
      blk_y_q     <= '0;
      ybase_q     <= '0;
      rbase_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      flags_q     <= '0;
      idx_q       <= '0;
      expect_q    <= OP_FLAG;
      pend_push_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      blk_x_q     <= blk_x_d;
      blk_y_q     <= blk_y_d;
      ybase_q     <= ybase_d;
      rbase_q     <= rbase_d;
      row_q       <= row_d;
      col_q       <= col_d;
      flags_q     <= flags_d;
      idx_q       <= idx_d;
      expect_q    <= expect_d;
      pend_push_q <= pend_push_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    pend_q <= pend_d;
  end

endmodule

>>> rtl/core/block_flag_fill_raw_expander_unit.sv
// ----------------------------------------------------------------------------
// block_flag_fill_raw_expander_unit: block flag/fill/raw image expander
// Walks an image in square blocks and turns flag, fill and raw items into
// one pixel write beat per written pixel.
// ----------------------------------------------------------------------------
// A flag byte or a raw sample is taken every cycle while no fill or skip
// runs and the result queue has room, and passes the input register, then
// a two-entry result queue. A fill item emits one beat per pixel of its
// clipped block, one per cycle while the queue has room, and holds the
// engine until every pixel of the block (up to 64) is sent. In difference
// overlay mode each block skipped by a set flag takes one block-advance
// step, up to eight per flag byte. The byte offset is built from a running
// row base, so no multiplier sits in the pixel path. Register writes are
// always accepted, restart the block walk and must only be issued while
// the unit is idle.
module block_flag_fill_raw_expander_unit
  import bffre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bffre_in_if.sink    in_i,
  bffre_out_if.source out_o,
  bffre_cfg_if.sink   cfg_i
);

  cfg_t    cfg;
  logic    restart;
  logic    room;
  logic    push;
  result_t push_data;
  result_t head;

  bffre_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.reg_data),
    .cfg_o      (cfg),
    .restart_o  (restart)
  );

  bffre_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_op_i     (in_i.op),
    .in_data_i   (in_i.item_data),
    .room_i      (room),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bffre_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .pop_valid_o (out_o.valid),
    .pop_ready_i (out_o.ready),
    .pop_data_o  (head)
  );

  // Drive the result channel from the queue head
  assign out_o.pixel_valid = head.pixel_valid;
  assign out_o.pixel_x     = head.pixel_x;
  assign out_o.pixel_y     = head.pixel_y;
  assign out_o.byte_offset = head.byte_offset;
  assign out_o.pixel_value = head.pixel_value;
  assign out_o.block_done  = head.block_done;
  assign out_o.image_done  = head.image_done;
  assign out_o.kind_error  = head.kind_error;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the block flag/fill/raw expander
// Drives flag, fill and raw items and register writes through valid/ready
// channels with random gaps and stalls. A block walk tracker predicts every
// pixel write beat and compares the result channel with it field by field.
// ----------------------------------------------------------------------------
module tb;
  import bffre_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int TAIL_CYCLES  = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_SHOWN    = 10;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 23;
  localparam int SKIP_ITEMS   = 40;
  localparam int NOISE_PCT    = 12;

  // Item kind that is never valid, and register indexes past the list
  localparam logic [OP_W-1:0]      OP_UNUSED       = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  // Tracks the block walk and holds the pixel beats still to arrive
  class block_walk_tracker;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [SIDE_W-1:0]   side;
    logic                mode;
    logic [STRIDE_W-1:0] stride;
    logic [PLANE_W-1:0]  plane;

    int unsigned         blk_col;
    int unsigned         blk_row;
    int unsigned         row_in_blk;
    int unsigned         col_in_blk;
    logic [FLAG_W-1:0]   flag_bits;
    int unsigned         bit_idx;
    logic [OP_W-1:0]     next_op;

    result_t             pending[$];
    int unsigned         mismatches;
    int unsigned         items_taken;
    int unsigned         beats_seen;
    int unsigned         image_ends;
    int unsigned         dropped;

    function new();
      width  = 13'd256;
      height = 13'd256;
      side   = 4'd8;
      mode   = 1'b0;
      stride = 3'd4;
      plane  = 2'd0;
      mismatches  = 0;
      items_taken = 0;
      beats_seen  = 0;
      image_ends  = 0;
      dropped     = 0;
      restart();
    endfunction

    function void restart();
      blk_col    = 0;
      blk_row    = 0;
      row_in_blk = 0;
      col_in_blk = 0;
      flag_bits  = '0;
      bit_idx    = 0;
      next_op    = OP_FLAG;
    endfunction

    function int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_w();
      return bound(32'(width), 1, MAX_DIM);
    endfunction

    function int unsigned eff_h();
      return bound(32'(height), 1, MAX_DIM);
    endfunction

    function int unsigned eff_side();
      return bound(32'(side), 1, MAX_BLOCK);
    endfunction

    // Span of a block clipped at the image edge
    function int unsigned clip_span(int unsigned start, int unsigned total, int unsigned s);
      if (start >= total) return 1;
      if (total - start < s) return total - start;
      return s;
    endfunction

    function bit cur_bit();
      return (flag_bits & (FIRST_FLAG_BIT >> bit_idx[2:0])) != '0;
    endfunction

    function logic [OP_W-1:0] expected_op();
      return next_op;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    // Register write: any known index restarts the walk
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:     width  = val[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    height = val[DIM_W-1:0];
        REG_BLOCK_SIDE:      side   = val[SIDE_W-1:0];
        REG_DECODE_MODE:     mode   = val[0];
        REG_BYTES_PER_PIXEL: stride = val[STRIDE_W-1:0];
        REG_PLANE_SELECT:    plane  = val[PLANE_W-1:0];
        default:             return;
      endcase
      restart();
    endfunction

    // Step past the current block; skip set-flag blocks in overlay mode.
    // Returns 1 when the image is finished.
    function bit close_block();
      int unsigned s;
      int unsigned ncols;
      int unsigned nrows;
      bit          fin;
      bit          stop;
      s     = eff_side();
      ncols = (eff_w() + s - 1) / s;
      nrows = (eff_h() + s - 1) / s;
      fin   = 1'b0;
      stop  = 1'b0;
      while (!stop) begin
        row_in_blk = 0;
        col_in_blk = 0;
        blk_col++;
        if (blk_col >= ncols) begin
          blk_col = 0;
          blk_row++;
        end
        if (blk_row >= nrows) begin
          restart();
          fin  = 1'b1;
          stop = 1'b1;
        end else if (bit_idx >= 7) begin
          bit_idx = 0;
          next_op = OP_FLAG;
          stop    = 1'b1;
        end else begin
          bit_idx++;
          if (!mode) begin
            next_op = cur_bit() ? OP_FILL : OP_RAW;
            stop    = 1'b1;
          end else if (!cur_bit()) begin
            next_op = OP_RAW;
            stop    = 1'b1;
          end
        end
      end
      return fin;
    endfunction

    function result_t pixel_beat(int unsigned x, int unsigned y, logic [DATA_W-1:0] data);
      result_t     r;
      int unsigned pix;
      int unsigned off;
      r   = '0;
      pix = y * eff_w() + x;
      r.pixel_valid = 1'b1;
      r.pixel_x     = x[COORD_W-1:0];
      r.pixel_y     = y[COORD_W-1:0];
      if (mode) begin
        off           = pix * 4;
        r.pixel_value = data;
      end else begin
        off           = pix * bound(32'(stride), 1, 4) + 32'(plane);
        r.pixel_value = {24'd0, data[7:0]};
      end
      r.byte_offset = off[OFF_W-1:0];
      return r;
    endfunction

    // Note an accepted item and queue the beats it causes
    function void take_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] data);
      int unsigned s;
      int unsigned x0;
      int unsigned y0;
      int unsigned bw;
      int unsigned bh;
      result_t     r;
      bit          fin;
      s   = eff_side();
      x0  = blk_col * s;
      y0  = blk_row * s;
      bw  = clip_span(x0, eff_w(), s);
      bh  = clip_span(y0, eff_h(), s);
      fin = 1'b0;
      items_taken++;
      // Drop an item of the wrong kind, state untouched
      if (op != next_op) begin
        r            = '0;
        r.kind_error = 1'b1;
        r.block_done = 1'b1;
        pending.push_back(r);
        dropped++;
        return;
      end
      if (op == OP_FLAG) begin
        flag_bits = data[FLAG_W-1:0];
        bit_idx   = 0;
        if (!mode) next_op = cur_bit() ? OP_FILL : OP_RAW;
        else if (!cur_bit()) next_op = OP_RAW;
        else fin = close_block();
        if (!fin) return;
        r = '0;
        pending.push_back(r);
      end else if (op == OP_FILL) begin
        for (int unsigned i = 0; i < bh; i++) begin
          for (int unsigned j = 0; j < bw; j++) begin
            pending.push_back(pixel_beat(x0 + j, y0 + i, data));
          end
        end
        fin = close_block();
      end else begin
        pending.push_back(pixel_beat(x0 + (col_in_blk & 7), y0 + (row_in_blk & 7), data));
        col_in_blk++;
        if (col_in_blk >= bw) begin
          col_in_blk = 0;
          row_in_blk++;
          if (row_in_blk >= bh) fin = close_block();
        end
      end
      // Mark the last beat of this item
      r = pending.pop_back();
      r.block_done = 1'b1;
      r.image_done = fin;
      pending.push_back(r);
      if (fin) image_ends++;
    endfunction

    function string show(result_t r);
      return $sformatf("pv=%0d x=%0d y=%0d off=%0d val=%08h bd=%0d id=%0d ke=%0d",
                       r.pixel_valid, r.pixel_x, r.pixel_y, r.byte_offset,
                       r.pixel_value, r.block_done, r.image_done, r.kind_error);
    endfunction

    function void complain(string what, result_t want_r, result_t got);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("%t mismatch (%s)\n  expected %s\n  actual   %s",
                 $realtime, what, show(want_r), show(got));
      end
    endfunction

    // Compare one accepted beat with the oldest expected one
    function void match_beat(result_t got);
      result_t w;
      beats_seen++;
      if (pending.size() == 0) begin
        complain("no beat expected", '0, got);
        return;
      end
      w = pending.pop_front();
      if (got.pixel_valid !== w.pixel_valid || got.pixel_x !== w.pixel_x ||
          got.pixel_y !== w.pixel_y || got.byte_offset !== w.byte_offset ||
          got.pixel_value !== w.pixel_value || got.block_done !== w.block_done ||
          got.image_done !== w.image_done || got.kind_error !== w.kind_error) begin
        complain("field differs", w, got);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni;
  bit   quiet;
  int unsigned settings_loaded;

  block_walk_tracker walk;

  bffre_in_if  in_if ();
  bffre_out_if out_if ();
  bffre_cfg_if cfg_if ();

  block_flag_fill_raw_expander_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Hold off, present one item and wait until the item is taken
  task automatic push_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.item_data <= data;
    do @(posedge clk_i); while (!in_if.ready);
    walk.take_item(op, data);
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline drain
  task automatic settle();
    in_if.valid <= 1'b0;
    while (walk.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.reg_data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    walk.write_reg(idx, val);
  endtask

  task automatic load_config(input logic [REG_DATA_W-1:0] w, input logic [REG_DATA_W-1:0] h,
                             input logic [REG_DATA_W-1:0] s, input logic [REG_DATA_W-1:0] m,
                             input logic [REG_DATA_W-1:0] bpp,
                             input logic [REG_DATA_W-1:0] pl);
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_BLOCK_SIDE, s);
    set_reg(REG_DECODE_MODE, m);
    set_reg(REG_BYTES_PER_PIXEL, bpp);
    set_reg(REG_PLANE_SELECT, pl);
    // A write past the list must leave the walk alone
    set_reg($urandom_range(0, 1) ? REG_SPARE_LAST : REG_SPARE_FIRST,
            REG_DATA_W'($urandom_range(0, 8191)));
    cfg_if.valid <= 1'b0;
    settings_loaded++;
  endtask

  // Fill the bits above the register's field with random junk
  function automatic logic [REG_DATA_W-1:0] noisy(logic [REG_DATA_W-1:0] v, int keep);
    logic [REG_DATA_W-1:0] junk;
    logic [REG_DATA_W-1:0] mask;
    junk = REG_DATA_W'($urandom_range(0, 8191));
    mask = (13'd1 << keep) - 13'd1;
    return (v & mask) | (junk & ~mask);
  endfunction

  // Mostly the kind the walk expects, with random content; some noise
  function automatic void draw_item(input int noise_pct, output logic [OP_W-1:0] op,
                                    output logic [DATA_W-1:0] data);
    data = $urandom;
    if ($urandom_range(0, 99) < noise_pct) op = OP_W'($urandom_range(0, 3));
    else op = walk.expected_op();
    if (op == OP_FLAG) begin
      case ($urandom_range(0, 3))
        0:       data[7:0] = 8'h00;
        1:       data[7:0] = 8'hFF;
        default: ;
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0:       data = 32'h0000_0000;
        1:       data = 32'hFFFF_FFFF;
        default: ;
      endcase
    end
  endfunction

  task automatic run_random(input int quota);
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data;
    int                formed;
    formed = 0;
    while (formed < quota) begin
      draw_item(NOISE_PCT, op, data);
      if (op == walk.expected_op()) formed++;
      push_item(op, data);
    end
  endtask

  // Result side: stall at random, then take and check one beat
  initial begin
    int unsigned stall;
    result_t     beat;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      beat.pixel_valid = out_if.pixel_valid;
      beat.pixel_x     = out_if.pixel_x;
      beat.pixel_y     = out_if.pixel_y;
      beat.byte_offset = out_if.byte_offset;
      beat.pixel_value = out_if.pixel_value;
      beat.block_done  = out_if.block_done;
      beat.image_done  = out_if.image_done;
      beat.kind_error  = out_if.kind_error;
      walk.match_beat(beat);
    end
  end

  // Watchdog: end the run when no channel moves a beat for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%t watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] data;
    logic [REG_DATA_W-1:0] rw;
    logic [REG_DATA_W-1:0] rh;
    logic [REG_DATA_W-1:0] rs;
    walk = new();
    quiet = 1'b0;
    settings_loaded = 0;
    in_if.valid      <= 1'b0;
    in_if.op         <= OP_FLAG;
    in_if.item_data  <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= REG_IMAGE_WIDTH;
    cfg_if.reg_data  <= '0;
    rst_ni           <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Plane fill on a 3x2 image of 2x2 blocks: wrong kinds, fill, clipped raw block
    load_config(13'd3, 13'd2, 13'd2, 13'd0, 13'd1, 13'd3);
    push_item(OP_RAW, 32'h0000_005A);
    push_item(OP_UNUSED, 32'hFFFF_FFFF);
    push_item(OP_FLAG, 32'hABCD_EF80);
    push_item(OP_RAW, 32'h0000_0011);
    push_item(OP_FILL, 32'hFFFF_FFFF);
    push_item(OP_FILL, 32'h0000_0000);
    push_item(OP_RAW, 32'h0000_0000);
    push_item(OP_RAW, 32'hFFFF_FF55);
    settle();

    // Overlay on a 2x1 image of single pixels: fill refused, skips to image end
    load_config(13'd2, 13'd1, 13'd1, 13'd1, 13'd4, 13'd0);
    push_item(OP_FILL, 32'h0000_0001);
    push_item(OP_FLAG, 32'h5A5A_5A40);
    push_item(OP_RAW, 32'h1234_5678);
    push_item(OP_FLAG, 32'h0000_00FF);
    push_item(OP_FLAG, 32'hFFFF_FF00);
    push_item(OP_RAW, 32'hFFFF_FFFF);
    push_item(OP_RAW, 32'h0000_0000);
    settle();

    // Tall overlay image: skip down to the last block row, then carry on
    load_config(13'd2, 13'd4096, 13'd8, 13'd1, 13'd4, 13'd0);
    for (int i = 0; i < 63; i++) begin
      data = $urandom;
      data[7:0] = 8'hFF;
      push_item(OP_FLAG, data);
    end
    data = $urandom;
    data[7:0] = 8'hFE;
    push_item(OP_FLAG, data);
    run_random(SKIP_ITEMS);
    settle();

    // Random phases over extreme, out of range and small random settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = ($urandom_range(0, 3) == 0);
      case (ph)
        0:       load_config(13'd4096, 13'd4096, 13'd1, 13'd0, 13'd4, 13'd3);
        1:       load_config(13'd1, 13'd1, 13'd8, 13'd1, 13'd1, 13'd0);
        2:       load_config(13'd0, 13'd8191, 13'd0, 13'd0, 13'd0, 13'd2);
        3:       load_config(13'd13, 13'd9, 13'd15, 13'd0, 13'd7, 13'd1);
        4:       load_config(13'd4096, 13'd1, 13'd8, 13'd1, 13'd2, 13'd3);
        default: begin
          rw = REG_DATA_W'($urandom_range(1, 24));
          rh = REG_DATA_W'($urandom_range(1, 24));
          rs = ($urandom_range(0, 7) == 0) ? REG_DATA_W'($urandom_range(0, 15)) :
                                             REG_DATA_W'($urandom_range(1, 8));
          load_config(rw, rh, noisy(rs, SIDE_W),
                      noisy(REG_DATA_W'($urandom_range(0, 1)), 1),
                      noisy(REG_DATA_W'($urandom_range(0, 7)), STRIDE_W),
                      noisy(REG_DATA_W'($urandom_range(0, 3)), PLANE_W));
        end
      endcase
      run_random(PHASE_ITEMS);
      settle();
    end
    quiet = 1'b0;

    $display("covered %0d items (%0d dropped as wrong kind), %0d result beats, %0d image ends",
             walk.items_taken, walk.dropped, walk.beats_seen, walk.image_ends);
    $display("over %0d register settings, both decode modes, clamped and extreme sizes",
             settings_loaded);
    if (walk.mismatches == 0 && walk.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/bffre_pkg.sv
rtl/core/bffre_if.sv
rtl/core/bffre_cfg_regs.sv
rtl/core/bffre_out_fifo.sv
rtl/core/bffre_engine.sv
rtl/core/block_flag_fill_raw_expander_unit.sv
test/tb.sv
